### sv/rhp_pkg.sv
// Shared widths, payload types and hue helpers of the rainbow HSL-to-RGB pixel pipeline.
package rhp_pkg;

    localparam int unsigned GRAY_W    = 8;
    localparam int unsigned COL_W     = 12;
    localparam int unsigned BW_W      = 13;
    localparam int unsigned CH_W      = 8;
    localparam int unsigned HUE_W     = 9;
    localparam int unsigned WGT_W     = 6;
    localparam int unsigned LVL_W     = 16;
    localparam int unsigned NUM_W     = 22;
    localparam int unsigned SCALE_W   = 26;
    localparam int unsigned FAC_W     = 10;
    localparam int unsigned EST_W     = 4;
    localparam int unsigned CHANNELS  = 3;

    localparam int unsigned DIV_STEP   = 3;
    localparam int unsigned DIV_STAGES = COL_W / DIV_STEP;

    localparam int unsigned MAX_COLUMNS_DEF = 4096;
    localparam int unsigned COL_MAX         = (1 << COL_W) - 1;
    localparam int unsigned BW_RESET        = 1;

    localparam int unsigned HUE_WRAP     = 360;
    localparam int unsigned RAMP_LEN     = 60;
    localparam int unsigned PLATEAU_END  = 180;
    localparam int unsigned FALL_END     = 240;
    localparam int unsigned RED_OFS      = 120;
    localparam int unsigned BLUE_OFS     = 240;

    // floor(q * 182 / 2^16) is floor(q / 360) or one below it for q < 4096
    localparam int unsigned MOD_RECIP = 182;
    localparam int unsigned MOD_SHIFT = 16;

    // 255 / 60 = 17 / 4, so floor(255 * N / (60 * 2^16)) = (17 * N) >> 18
    localparam int unsigned SCALE_MUL   = 17;
    localparam int unsigned SCALE_SHIFT = 18;

    localparam int unsigned CH_RED   = 0;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_BLUE  = 2;

    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        logic [COL_W-1:0]  column;
    } pix_in_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pix_out_t;

    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        logic [BW_W-1:0]   rem;
        logic [COL_W-1:0]  num;
    } div_word_t;

    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        logic [HUE_W-1:0]  hue;
    } hue_word_t;

    // Degree plus a fixed offset, wrapped back into 0..359
    function automatic logic [HUE_W-1:0] hue_shift(input logic [HUE_W-1:0] d,
                                                   input logic [HUE_W:0]   ofs);
        logic [HUE_W:0] s;
        s = {1'b0, d} + ofs;
        if (s >= (HUE_W+1)'(HUE_WRAP))
        begin
            s = s - (HUE_W+1)'(HUE_WRAP);
        end
        return s[HUE_W-1:0];
    endfunction

    // Share of (v2 - v1) in sixtieths: rising ramp, plateau, falling ramp, floor
    function automatic logic [WGT_W-1:0] hue_weight(input logic [HUE_W-1:0] d);
        logic [HUE_W-1:0] fall;
        fall = HUE_W'(FALL_END) - d;
        priority if (d < HUE_W'(RAMP_LEN))
        begin
            return d[WGT_W-1:0];
        end
        else if (d < HUE_W'(PLATEAU_END))
        begin
            return WGT_W'(RAMP_LEN);
        end
        else if (d < HUE_W'(FALL_END))
        begin
            return fall[WGT_W-1:0];
        end
        else
        begin
            return '0;
        end
    endfunction

endpackage

### sv/rhp_stream_if.sv
// Valid/ready stream channel carrying one payload of type T.
interface rhp_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/rhp_div_stage.sv
// One slice of the pipelined restoring divider: three quotient bits per stage.
module rhp_div_stage (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [rhp_pkg::BW_W-1:0] divisor,
    rhp_stream_if.sink               up,
    rhp_stream_if.source             down
);
    import rhp_pkg::*;

    logic            valid_reg;
    div_word_t       word_reg;
    div_word_t       word_next;
    logic [BW_W:0]   trial;
    logic            take;

    always_comb
    begin
        word_next = up.data;
        trial     = '0;
        take      = 1'b0;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            trial          = {word_next.rem, word_next.num[COL_W-1]};
            take           = (trial >= {1'b0, divisor});
            word_next.num  = {word_next.num[COL_W-2:0], take};
            if (take)
            begin
                word_next.rem = BW_W'(trial - {1'b0, divisor});
            end
            else
            begin
                word_next.rem = trial[BW_W-1:0];
            end
        end
    end

    assign up.ready   = !valid_reg || down.ready;
    assign down.valid = valid_reg;
    assign down.data  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up.ready)
        begin
            valid_reg <= up.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up.ready && up.valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

### sv/rhp_hue_wrap.sv
// Quotient modulo 360 in two stages: reciprocal estimate, then subtract and correct.
module rhp_hue_wrap (
    input  logic         clk,
    input  logic         rst_n,
    rhp_stream_if.sink   up,
    rhp_stream_if.source down
);
    import rhp_pkg::*;

    localparam int unsigned PROD_W = COL_W + 8;

    logic [PROD_W-1:0] prod;
    logic [EST_W-1:0]  est_next;

    logic              a_valid_reg;
    logic [GRAY_W-1:0] a_gray_reg;
    logic [COL_W-1:0]  a_q_reg;
    logic [EST_W-1:0]  a_est_reg;
    logic              a_ready;

    logic [COL_W-1:0]  rem;
    logic [COL_W-1:0]  fixed;
    hue_word_t         b_word_next;
    logic              b_valid_reg;
    hue_word_t         b_word_reg;
    logic              b_ready;

    assign prod     = PROD_W'(up.data.num) * PROD_W'(MOD_RECIP);
    assign est_next = prod[MOD_SHIFT +: EST_W];

    // estimate is exact or one short, so the remainder stays below 720
    always_comb
    begin
        rem = a_q_reg - COL_W'(a_est_reg * HUE_WRAP);
        if (rem >= COL_W'(HUE_WRAP))
        begin
            fixed = rem - COL_W'(HUE_WRAP);
        end
        else
        begin
            fixed = rem;
        end
        b_word_next.gray = a_gray_reg;
        b_word_next.hue  = fixed[HUE_W-1:0];
    end

    assign b_ready    = !b_valid_reg || down.ready;
    assign a_ready    = !a_valid_reg || b_ready;
    assign up.ready   = a_ready;
    assign down.valid = b_valid_reg;
    assign down.data  = b_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= up.valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && up.valid)
        begin
            a_gray_reg <= up.data.gray;
            a_q_reg    <= up.data.num;
            a_est_reg  <= est_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_word_reg <= b_word_next;
        end
    end

endmodule

### sv/rhp_shade.sv
// Lightness levels, per-channel hue weights, ramp products and the output register.
module rhp_shade (
    input  logic         clk,
    input  logic         rst_n,
    rhp_stream_if.sink   up,
    rhp_stream_if.source down
);
    import rhp_pkg::*;

    localparam int unsigned PROD_W = GRAY_W + FAC_W;

    logic [FAC_W-1:0]  fac;
    logic [PROD_W-1:0] prod;
    logic [LVL_W-1:0]  hi;
    logic [LVL_W:0]    lo_wide;
    logic [LVL_W-1:0]  lo_next;
    logic [LVL_W-1:0]  diff_next;
    logic [WGT_W-1:0]  wgt_next [CHANNELS];

    logic              c1_valid_reg;
    logic [LVL_W-1:0]  c1_lo_reg;
    logic [LVL_W-1:0]  c1_diff_reg;
    logic [WGT_W-1:0]  c1_wgt_reg [CHANNELS];
    logic              c1_ready;

    logic [NUM_W-1:0]  num_next [CHANNELS];
    logic              c2_valid_reg;
    logic [NUM_W-1:0]  c2_num_reg [CHANNELS];
    logic              c2_ready;

    logic [SCALE_W-1:0] scaled [CHANNELS];
    pix_out_t           out_next;
    logic               out_valid_reg;
    pix_out_t           out_reg;
    logic               out_ready;

    // v2 = g*(256+g) below mid-grey, g*(512-g) above; v1 = 2L - v2
    always_comb
    begin
        if (up.data.gray[GRAY_W-1])
        begin
            fac = FAC_W'(512) - FAC_W'(up.data.gray);
        end
        else
        begin
            fac = FAC_W'(256) + FAC_W'(up.data.gray);
        end
        prod      = PROD_W'(up.data.gray) * PROD_W'(fac);
        hi        = prod[LVL_W-1:0];
        lo_wide   = {up.data.gray, 9'b0} - {1'b0, hi};
        lo_next   = lo_wide[LVL_W-1:0];
        diff_next = hi - lo_next;
        wgt_next[CH_RED]   = hue_weight(hue_shift(up.data.hue, (HUE_W+1)'(RED_OFS)));
        wgt_next[CH_GREEN] = hue_weight(up.data.hue);
        wgt_next[CH_BLUE]  = hue_weight(hue_shift(up.data.hue, (HUE_W+1)'(BLUE_OFS)));
    end

    always_comb
    begin
        for (int k = 0; k < CHANNELS; k++)
        begin
            num_next[k] = NUM_W'(c1_lo_reg) * NUM_W'(RAMP_LEN)
                        + NUM_W'(c1_diff_reg) * NUM_W'(c1_wgt_reg[k]);
            scaled[k]   = SCALE_W'(c2_num_reg[k]) * SCALE_W'(SCALE_MUL);
        end
        out_next.red   = scaled[CH_RED][SCALE_SHIFT +: CH_W];
        out_next.green = scaled[CH_GREEN][SCALE_SHIFT +: CH_W];
        out_next.blue  = scaled[CH_BLUE][SCALE_SHIFT +: CH_W];
    end

    assign out_ready  = !out_valid_reg || down.ready;
    assign c2_ready   = !c2_valid_reg || out_ready;
    assign c1_ready   = !c1_valid_reg || c2_ready;
    assign up.ready   = c1_ready;
    assign down.valid = out_valid_reg;
    assign down.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg  <= 1'b0;
            c2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (c1_ready)
            begin
                c1_valid_reg <= up.valid;
            end
            if (c2_ready)
            begin
                c2_valid_reg <= c1_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= c2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c1_ready && up.valid)
        begin
            c1_lo_reg   <= lo_next;
            c1_diff_reg <= diff_next;
            for (int k = 0; k < CHANNELS; k++)
            begin
                c1_wgt_reg[k] <= wgt_next[k];
            end
        end
        if (c2_ready && c1_valid_reg)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                c2_num_reg[k] <= num_next[k];
            end
        end
        if (out_ready && c2_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

endmodule

### sv/rainbow_hsl_to_rgb_pixel.sv
// Top level of the rainbow HSL-to-RGB pixel pipeline.
//
//   channel    dir  handshake            payload
//   pix_in     in   valid/ready          gray[7:0], column[11:0]
//   pix_out    out  valid/ready          red[7:0], green[7:0], blue[7:0]
//   cfg        in   cfg_we (no ready)    cfg_wdata[12:0] = band_width
//
// One pixel per clock while pix_out accepts: four divider stages of three quotient
// bits each (column / band_width), two stages for the modulo 360, then levels and
// weights, ramp products and the output register.
// Reset clears all valid bits and sets band_width to 1.
// A stall at pix_out backs up only through stages that hold a request; bubbles fill.
module rainbow_hsl_to_rgb_pixel #(
    parameter int unsigned MAX_COLUMNS = rhp_pkg::MAX_COLUMNS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [rhp_pkg::BW_W-1:0] cfg_wdata,
    rhp_stream_if.sink               pix_in,
    rhp_stream_if.source             pix_out
);
    import rhp_pkg::*;

    localparam int unsigned      LIMIT     = (MAX_COLUMNS - 1 > COL_MAX) ? COL_MAX
                                                                         : MAX_COLUMNS - 1;
    localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(LIMIT);

    logic [BW_W-1:0]  band_width_reg;
    logic [BW_W-1:0]  bw_eff;
    logic [COL_W-1:0] col_clamped;

    rhp_stream_if #(.T(div_word_t)) div_link [DIV_STAGES+1] ();
    rhp_stream_if #(.T(hue_word_t)) hue_link ();

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_width_reg <= BW_W'(BW_RESET);
        end
        else if (cfg_we)
        begin
            band_width_reg <= cfg_wdata;
        end
    end

    // treat a zero band width as one
    assign bw_eff      = (band_width_reg == '0) ? BW_W'(1) : band_width_reg;
    assign col_clamped = (pix_in.data.column > COL_LIMIT) ? COL_LIMIT : pix_in.data.column;

    assign div_link[0].valid = pix_in.valid;
    assign div_link[0].data  = '{gray: pix_in.data.gray, rem: '0, num: col_clamped};
    assign pix_in.ready      = div_link[0].ready;

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        rhp_div_stage u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .divisor (bw_eff),
            .up      (div_link[i]),
            .down    (div_link[i+1])
        );
    end

    rhp_hue_wrap u_hue (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (div_link[DIV_STAGES]),
        .down  (hue_link)
    );

    rhp_shade u_shade (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (hue_link),
        .down  (pix_out)
    );

`ifndef ASSERT_OFF
    a_ready_chain : assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.ready |-> pix_in.ready)
        else $error("ready chain blocked with the output free");

    a_div_rem : assert property (@(posedge clk) disable iff (!rst_n)
        div_link[DIV_STAGES].valid |-> (div_link[DIV_STAGES].data.rem < bw_eff))
        else $error("divider remainder not below band width");

    a_hue_range : assert property (@(posedge clk) disable iff (!rst_n)
        hue_link.valid |-> (hue_link.data.hue < HUE_W'(HUE_WRAP)))
        else $error("hue out of range");

    a_out_range : assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid |-> (pix_out.data.red != 8'hFF && pix_out.data.green != 8'hFF
                           && pix_out.data.blue != 8'hFF))
        else $error("channel value above 254");
`endif

endmodule
